// ----- hdl/ic3s_pkg.sv -----
// ----------------------------------------------------------------------------
// ic3s_pkg: shared types and constants of the 3x3 convolution stream
// Pixel and coefficient widths, configuration register indexes, the window
// word and the kernel settings that travel from the register file to the
// arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ic3s_pkg;

    localparam int PIX_W       = 16;
    localparam int KDIM        = 3;
    localparam int CFG_DATA_W  = 48;
    localparam int CFG_INDEX_W = 3;
    localparam int SIZE_W      = 11;
    localparam int SHIFT_W     = 6;
    localparam int PROD_W      = 32;
    localparam int ROW_SUM_W   = 34;
    localparam int SUM_W       = 40;

    localparam int MIN_SIZE    = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 11'd10;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd15;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 6'd39;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KERNEL_TOP    = 3'd0,
        REG_KERNEL_MIDDLE = 3'd1,
        REG_KERNEL_BOTTOM = 3'd2,
        REG_IMAGE_WIDTH   = 3'd3,
        REG_IMAGE_HEIGHT  = 3'd4,
        REG_RESULT_SHIFT  = 3'd5
    } cfg_reg_t;

    typedef logic signed [PIX_W-1:0] pix_t;

    // pix[row][column], row 0 on top, column 0 on the left
    typedef struct packed {
        logic [KDIM-1:0][KDIM-1:0][PIX_W-1:0] pix;
    } window_t;

    typedef struct packed {
        logic [KDIM-1:0][KDIM-1:0][PIX_W-1:0] coef;
        logic [SHIFT_W-1:0]                   shift;
    } kern_cfg_t;

endpackage

`default_nettype wire

// ----- hdl/ic3s_front.sv -----
// ----------------------------------------------------------------------------
// ic3s_front: raster counters, line stores and window registers
// Accepts pixels, reads both line stores at the current column, assembles the
// 3x3 window in the next cycle and pushes it when the centre is interior.
// ----------------------------------------------------------------------------
`default_nettype none

module ic3s_front
    import ic3s_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    localparam int COL_W     = $clog2(MAX_WIDTH),
    localparam int ROW_W     = $clog2(MAX_HEIGHT)
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_fire,
    input  wire logic [PIX_W-1:0]   pixel_value,
    input  wire logic [SIZE_W-1:0]  width_cfg,
    input  wire logic [SIZE_W-1:0]  height_cfg,
    output logic                    push,
    output window_t                 push_window,
    output logic [COL_W-1:0]        push_col,
    output logic [ROW_W-1:0]        push_row,
    output logic                    push_last,
    output logic                    busy
);

    localparam int CCMP_W = (COL_W + 1 > SIZE_W) ? COL_W + 1 : SIZE_W;
    localparam int RCMP_W = (ROW_W + 1 > SIZE_W) ? ROW_W + 1 : SIZE_W;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [CCMP_W-1:0] width_ext, width_lim;
    logic [RCMP_W-1:0] height_ext, height_lim;
    logic              last_col, last_row, emit;

    logic              s1_valid_reg;
    pix_t              s1_pix_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic              s1_emit_reg;
    logic              s1_last_reg;
    pix_t              up_rd_reg;
    pix_t              lo_rd_reg;

    pix_t              upper_mem [MAX_WIDTH];
    pix_t              lower_mem [MAX_WIDTH];
    pix_t              win_reg   [6];

    // clamp the frame size to 3 .. maximum
    always_comb
    begin
        width_ext  = CCMP_W'(width_cfg);
        height_ext = RCMP_W'(height_cfg);
        if (width_ext < CCMP_W'(MIN_SIZE))
        begin
            width_lim = CCMP_W'(MIN_SIZE);
        end
        else if (width_ext > CCMP_W'(MAX_WIDTH))
        begin
            width_lim = CCMP_W'(MAX_WIDTH);
        end
        else
        begin
            width_lim = width_ext;
        end
        if (height_ext < RCMP_W'(MIN_SIZE))
        begin
            height_lim = RCMP_W'(MIN_SIZE);
        end
        else if (height_ext > RCMP_W'(MAX_HEIGHT))
        begin
            height_lim = RCMP_W'(MAX_HEIGHT);
        end
        else
        begin
            height_lim = height_ext;
        end
    end

    assign last_col = CCMP_W'(col_reg) >= width_lim - CCMP_W'(1);
    assign last_row = RCMP_W'(row_reg) >= height_lim - RCMP_W'(1);
    assign emit     = (col_reg >= COL_W'(2)) && (row_reg >= ROW_W'(2));

    always_comb
    begin
        col_next = col_reg + COL_W'(1);
        row_next = row_reg;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_fire;
            if (in_fire)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pix_reg  <= pix_t'(pixel_value);
            s1_col_reg  <= col_reg;
            s1_row_reg  <= row_reg;
            s1_emit_reg <= emit;
            s1_last_reg <= last_col && last_row;
        end
    end

    // line stores: read at accept, write back in the next cycle
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            up_rd_reg <= upper_mem[col_reg];
        end
        if (s1_valid_reg)
        begin
            upper_mem[s1_col_reg] <= lo_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            lo_rd_reg <= lower_mem[col_reg];
        end
        if (s1_valid_reg)
        begin
            lower_mem[s1_col_reg] <= s1_pix_reg;
        end
    end

    // advance the two stored window columns on every pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_valid_reg)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= up_rd_reg;
            win_reg[4] <= lo_rd_reg;
            win_reg[5] <= s1_pix_reg;
        end
    end

    always_comb
    begin
        for (int ky = 0; ky < KDIM; ky++)
        begin
            push_window.pix[ky][0] = win_reg[ky];
            push_window.pix[ky][1] = win_reg[3 + ky];
        end
        push_window.pix[0][2] = up_rd_reg;
        push_window.pix[1][2] = lo_rd_reg;
        push_window.pix[2][2] = s1_pix_reg;
    end

    assign push      = s1_valid_reg && s1_emit_reg;
    assign push_col  = s1_col_reg - COL_W'(1);
    assign push_row  = s1_row_reg - ROW_W'(1);
    assign push_last = s1_last_reg;
    assign busy      = s1_valid_reg;

endmodule

`default_nettype wire

// ----- hdl/ic3s_queue.sv -----
// ----------------------------------------------------------------------------
// ic3s_queue: short window queue between front and back
// Register FIFO; the producer checks space by credit, the consumer pops only
// when the count is nonzero.
// ----------------------------------------------------------------------------
`default_nettype none

module ic3s_queue
    import ic3s_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      pop_data,
    output logic [QCNT_W-1:0]      count
);

    logic [DATA_W-1:0] data_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = data_reg[rd_ptr_reg];
    assign count    = count_reg;

endmodule

`default_nettype wire

// ----- hdl/ic3s_back.sv -----
// ----------------------------------------------------------------------------
// ic3s_back: multiply, accumulate, shift and output register
// Four stages: nine products, three row sums, the 40-bit total, and the
// shifted result in the output register. The stages hold together while the
// output word waits.
// ----------------------------------------------------------------------------
`default_nettype none

module ic3s_back
    import ic3s_pkg::*;
#(
    parameter int COL_W = 10,
    parameter int ROW_W = 10
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire kern_cfg_t         kern,
    input  wire logic              q_nonempty,
    input  wire window_t           q_window,
    input  wire logic [COL_W-1:0]  q_col,
    input  wire logic [ROW_W-1:0]  q_row,
    input  wire logic              q_last,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [PIX_W-1:0]       filtered_value,
    output logic [COL_W-1:0]       centre_column,
    output logic [ROW_W-1:0]       centre_row,
    output logic                   frame_last
);

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } meta_t;

    logic                        adv;
    logic                        p_valid_reg, r_valid_reg, t_valid_reg, o_valid_reg;
    meta_t                       p_meta_reg, r_meta_reg, t_meta_reg, o_meta_reg;
    logic signed [PROD_W-1:0]    prod_reg [KDIM][KDIM];
    logic signed [ROW_SUM_W-1:0] row_sum_reg [KDIM];
    logic signed [SUM_W-1:0]     total_reg;
    logic signed [SUM_W-1:0]     shifted;
    logic [SHIFT_W-1:0]          shift_lim;
    logic [PIX_W-1:0]            o_value_reg;

    // hold every stage while the output word waits
    assign adv = !o_valid_reg || out_ready;
    assign pop = adv && q_nonempty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
            t_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_valid_reg <= pop;
            r_valid_reg <= p_valid_reg;
            t_valid_reg <= r_valid_reg;
            o_valid_reg <= t_valid_reg;
        end
    end

    assign shift_lim = (kern.shift > SHIFT_MAX) ? SHIFT_MAX : kern.shift;
    assign shifted   = total_reg >>> shift_lim;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int ky = 0; ky < KDIM; ky++)
            begin
                for (int kx = 0; kx < KDIM; kx++)
                begin
                    prod_reg[ky][kx] <= $signed(q_window.pix[ky][kx])
                                      * $signed(kern.coef[ky][kx]);
                end
                row_sum_reg[ky] <= ROW_SUM_W'(prod_reg[ky][0])
                                 + ROW_SUM_W'(prod_reg[ky][1])
                                 + ROW_SUM_W'(prod_reg[ky][2]);
            end
            total_reg   <= SUM_W'(row_sum_reg[0]) + SUM_W'(row_sum_reg[1])
                         + SUM_W'(row_sum_reg[2]);
            o_value_reg <= shifted[PIX_W-1:0];

            p_meta_reg.col  <= q_col;
            p_meta_reg.row  <= q_row;
            p_meta_reg.last <= q_last;
            r_meta_reg      <= p_meta_reg;
            t_meta_reg      <= r_meta_reg;
            o_meta_reg      <= t_meta_reg;
        end
    end

    assign out_valid      = o_valid_reg;
    assign filtered_value = o_value_reg;
    assign centre_column  = o_meta_reg.col;
    assign centre_row     = o_meta_reg.row;
    assign frame_last     = o_meta_reg.last;

endmodule

`default_nettype wire

// ----- hdl/image_conv3x3_stream.sv -----
// ----------------------------------------------------------------------------
// image_conv3x3_stream: streaming 3x3 convolution over signed 16-bit pixels
// Pixels enter in raster order on the in_valid/in_ready channel. Each
// interior pixel position yields one word on out_valid/out_ready: the
// 40-bit sum of the window times the kernel, shifted right arithmetically
// and cut to 16 bits, with the centre coordinates and an end-of-frame flag.
// Border rows and columns give no word.
//
// Throughput is one pixel per clock while in_ready stays high. The front
// (counters, two line stores with one read and one write port each, window
// registers) never stalls once a pixel is taken; in_ready drops only when the
// four-entry window queue plus the word in the front would leave no room.
// On its way to out_valid a pixel passes the line store read register and the
// queue, then the product, row sum, total and output stages. When out_ready
// is low the whole back half holds, the queue fills and then in_ready falls;
// no word is dropped. Reset clears counters, window, queue and pipeline; the
// line stores need no clearing. Configuration (cfg_we, cfg_index, cfg_data)
// is to be written by the user only while the block is idle; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module image_conv3x3_stream
    import ic3s_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    localparam int COL_W     = $clog2(MAX_WIDTH),
    localparam int ROW_W     = $clog2(MAX_HEIGHT)
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration write port
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    // pixel input
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [PIX_W-1:0]       pixel_value,
    // filtered output
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [PIX_W-1:0]            filtered_value,
    output logic [COL_W-1:0]            centre_column,
    output logic [ROW_W-1:0]            centre_row,
    output logic                        frame_last
);

    localparam int Q_W = $bits(window_t) + COL_W + ROW_W + 1;

    logic [CFG_DATA_W-1:0] kernel_top_reg;
    logic [CFG_DATA_W-1:0] kernel_middle_reg;
    logic [CFG_DATA_W-1:0] kernel_bottom_reg;
    logic [SIZE_W-1:0]     width_reg;
    logic [SIZE_W-1:0]     height_reg;
    logic [SHIFT_W-1:0]    shift_reg;
    kern_cfg_t             kern;

    logic                  in_fire;
    logic                  front_push;
    window_t               front_window;
    logic [COL_W-1:0]      front_col;
    logic [ROW_W-1:0]      front_row;
    logic                  front_last;
    logic                  front_busy;

    logic                  q_pop;
    logic [Q_W-1:0]        q_push_data;
    logic [Q_W-1:0]        q_pop_data;
    logic [QCNT_W-1:0]     q_count;
    window_t               q_window;
    logic [COL_W-1:0]      q_col;
    logic [ROW_W-1:0]      q_row;
    logic                  q_last;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_top_reg    <= '0;
            kernel_middle_reg <= '0;
            kernel_bottom_reg <= '0;
            width_reg         <= SIZE_RESET;
            height_reg        <= SIZE_RESET;
            shift_reg         <= SHIFT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KERNEL_TOP:    kernel_top_reg    <= cfg_data;
                REG_KERNEL_MIDDLE: kernel_middle_reg <= cfg_data;
                REG_KERNEL_BOTTOM: kernel_bottom_reg <= cfg_data;
                REG_IMAGE_WIDTH:   width_reg         <= cfg_data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT:  height_reg        <= cfg_data[SIZE_W-1:0];
                REG_RESULT_SHIFT:  shift_reg         <= cfg_data[SHIFT_W-1:0];
                default:           ;
            endcase
        end
    end

    // split kernel rows into coefficients: left column in the low bits
    always_comb
    begin
        for (int kx = 0; kx < KDIM; kx++)
        begin
            kern.coef[0][kx] = kernel_top_reg[PIX_W*kx +: PIX_W];
            kern.coef[1][kx] = kernel_middle_reg[PIX_W*kx +: PIX_W];
            kern.coef[2][kx] = kernel_bottom_reg[PIX_W*kx +: PIX_W];
        end
        kern.shift = shift_reg;
    end

    // take a pixel only when the queue can absorb everything in flight
    assign in_ready = (q_count + QCNT_W'(front_busy)) < QCNT_W'(QUEUE_DEPTH);
    assign in_fire  = in_valid && in_ready;

    ic3s_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .pixel_value (pixel_value),
        .width_cfg   (width_reg),
        .height_cfg  (height_reg),
        .push        (front_push),
        .push_window (front_window),
        .push_col    (front_col),
        .push_row    (front_row),
        .push_last   (front_last),
        .busy        (front_busy)
    );

    assign q_push_data = {front_window, front_col, front_row, front_last};

    ic3s_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .count     (q_count)
    );

    assign {q_window, q_col, q_row, q_last} = q_pop_data;

    ic3s_back #(
        .COL_W (COL_W),
        .ROW_W (ROW_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .kern           (kern),
        .q_nonempty     (q_count != '0),
        .q_window       (q_window),
        .q_col          (q_col),
        .q_row          (q_row),
        .q_last         (q_last),
        .pop            (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .filtered_value (filtered_value),
        .centre_column  (centre_column),
        .centre_row     (centre_row),
        .frame_last     (frame_last)
    );

endmodule

`default_nettype wire

// ----- hdl/ic3s_checker.sv -----
// ----------------------------------------------------------------------------
// ic3s_checker: port-level checks of the 3x3 convolution stream
// Watches reset behavior, output word stability and interior coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module ic3s_checker
    import ic3s_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    localparam int COL_W     = $clog2(MAX_WIDTH),
    localparam int ROW_W     = $clog2(MAX_HEIGHT)
)
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [PIX_W-1:0]  filtered_value,
    input wire logic [COL_W-1:0]  centre_column,
    input wire logic [ROW_W-1:0]  centre_row,
    input wire logic              frame_last
);

    // no word while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("out_valid high during reset");

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({filtered_value, centre_column, centre_row, frame_last}))
        else $error("output word changed while stalled");

    // only interior centres are reported
    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> centre_column != '0 && centre_row != '0)
        else $error("border position reported");

    // the input side opens right after reset
    a_ready_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |=> in_ready)
        else $error("in_ready low after reset");

endmodule

bind image_conv3x3_stream ic3s_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
) u_ic3s_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .filtered_value (filtered_value),
    .centre_column  (centre_column),
    .centre_row     (centre_row),
    .frame_last     (frame_last)
);

`default_nettype wire

// ----- sim/image_conv3x3_stream_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_conv3x3_stream_test: self-checking bench for the 3x3 convolution stream
// Drives signed pixels into the block in raster order and mirrors the line
// stores, window and counters in a scoreboard that predicts every filtered
// word. Sweeps kernel, size and shift settings between bursts, including
// sizes and shifts beyond their legal range and a size cut in mid-frame.
// Both handshakes idle at random, and some bursts run with no idling.
// ----------------------------------------------------------------------------

module image_conv3x3_stream_test;
    import ic3s_pkg::*;

    localparam int COORD_W       = 10;
    localparam int LINE_DEPTH    = 1024;
    localparam int MAX_SIDE      = 1024;
    localparam int RANDOM_PIXELS = 1650;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int REPORT_CAP    = 60;

    localparam logic [31:0] COUNT_MASK = 32'h3FF;

    // indexes with no register behind them; a write there changes nothing
    localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_B = 3'd7;

    localparam pix_t PIX_MIN = 16'sh8000;
    localparam pix_t PIX_MAX = 16'sh7FFF;

    typedef struct packed {
        logic [PIX_W-1:0]   value;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               last;
    } conv_word_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow copy of the filter state, the queue of words still
    // owed by the block, and the comparison of each word that comes out.
    // ------------------------------------------------------------------------
    class conv_scoreboard;
        logic [CFG_DATA_W-1:0] kernel_rows [KDIM];
        logic [SIZE_W-1:0]     width_reg;
        logic [SIZE_W-1:0]     height_reg;
        logic [SHIFT_W-1:0]    shift_reg;
        pix_t                  upper_line [LINE_DEPTH];
        pix_t                  lower_line [LINE_DEPTH];
        // [0..2] column c-2 top to bottom, [3..5] column c-1
        pix_t                  prev_cols [6];
        int unsigned           col_cnt;
        int unsigned           row_cnt;
        conv_word_t            pending_words [$];
        int unsigned           error_count;

        function new();
            for (int k = 0; k < KDIM; k++)
                kernel_rows[k] = '0;
            width_reg   = SIZE_RESET;
            height_reg  = SIZE_RESET;
            shift_reg   = SHIFT_RESET;
            for (int k = 0; k < 6; k++)
                prev_cols[k] = '0;
            for (int k = 0; k < LINE_DEPTH; k++)
            begin
                upper_line[k] = '0;
                lower_line[k] = '0;
            end
            col_cnt     = 0;
            row_cnt     = 0;
            error_count = 0;
        endfunction

        function int unsigned clamp_side(logic [SIZE_W-1:0] v);
            if (v < MIN_SIZE)
                return MIN_SIZE;
            if (v > MAX_SIDE)
                return MAX_SIDE;
            return v;
        endfunction

        function int unsigned width_eff();
            return clamp_side(width_reg);
        endfunction

        function int unsigned height_eff();
            return clamp_side(height_reg);
        endfunction

        function bit mid_frame();
            return col_cnt != 0 || row_cnt != 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] reg_index,
                                logic [CFG_DATA_W-1:0] reg_data);
            case (reg_index)
                REG_KERNEL_TOP:    kernel_rows[0] = reg_data;
                REG_KERNEL_MIDDLE: kernel_rows[1] = reg_data;
                REG_KERNEL_BOTTOM: kernel_rows[2] = reg_data;
                REG_IMAGE_WIDTH:   width_reg      = reg_data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT:  height_reg     = reg_data[SIZE_W-1:0];
                REG_RESULT_SHIFT:  shift_reg      = reg_data[SHIFT_W-1:0];
                default: ;
            endcase
        endfunction

        // Walk copies of the counters forward until they are back at the origin.
        function int unsigned pixels_to_frame_end();
            int unsigned c;
            int unsigned r;
            int unsigned count;
            int unsigned w;
            int unsigned h;
            c     = col_cnt;
            r     = row_cnt;
            count = 0;
            w     = width_eff();
            h     = height_eff();
            do
            begin
                count++;
                if (c >= w - 1)
                begin
                    c = 0;
                    r = (r >= h - 1) ? 0 : ((r + 1) & COUNT_MASK);
                end
                else
                    c = (c + 1) & COUNT_MASK;
            end
            while (c != 0 || r != 0);
            return count;
        endfunction

        // Advance the shadow state by one accepted pixel and queue the word
        // the block owes for it, if the window is fully inside the frame.
        function void take_pixel(pix_t p);
            int unsigned w;
            int unsigned h;
            int unsigned idx;
            int unsigned s;
            int          ky;
            int          kx;
            pix_t        up;
            pix_t        lo;
            pix_t        coef;
            pix_t        win [KDIM][KDIM];
            longint      acc;
            bit          last_col;
            bit          last_row;
            conv_word_t  word;

            w        = width_eff();
            h        = height_eff();
            idx      = col_cnt % LINE_DEPTH;
            up       = upper_line[idx];
            lo       = lower_line[idx];
            last_col = col_cnt >= w - 1;
            last_row = row_cnt >= h - 1;

            win[0][0] = prev_cols[0];
            win[1][0] = prev_cols[1];
            win[2][0] = prev_cols[2];
            win[0][1] = prev_cols[3];
            win[1][1] = prev_cols[4];
            win[2][1] = prev_cols[5];
            win[0][2] = up;
            win[1][2] = lo;
            win[2][2] = p;

            if (row_cnt >= 2 && col_cnt >= 2)
            begin
                acc = 0;
                for (ky = 0; ky < KDIM; ky++)
                    for (kx = 0; kx < KDIM; kx++)
                    begin
                        coef = kernel_rows[ky][PIX_W*kx +: PIX_W];
                        acc += longint'(win[ky][kx]) * longint'(coef);
                    end
                s           = (shift_reg > SHIFT_MAX) ? SHIFT_MAX : shift_reg;
                acc         = acc >>> s;
                word.value  = acc[PIX_W-1:0];
                word.column = COORD_W'(col_cnt - 1);
                word.row    = COORD_W'(row_cnt - 1);
                word.last   = last_col && last_row;
                pending_words.push_back(word);
            end

            upper_line[idx] = lo;
            lower_line[idx] = p;
            prev_cols[0]    = prev_cols[3];
            prev_cols[1]    = prev_cols[4];
            prev_cols[2]    = prev_cols[5];
            prev_cols[3]    = up;
            prev_cols[4]    = lo;
            prev_cols[5]    = p;

            if (last_col)
            begin
                col_cnt = 0;
                row_cnt = last_row ? 0 : ((row_cnt + 1) & COUNT_MASK);
            end
            else
                col_cnt = (col_cnt + 1) & COUNT_MASK;
        endfunction

        task report(string what);
            if (error_count < REPORT_CAP)
                $display("MISMATCH at %0t ns: %s", $time, what);
            error_count++;
        endtask

        task check_word(conv_word_t got);
            conv_word_t want;
            if (pending_words.size() == 0)
            begin
                report($sformatf("unexpected word %0d at column %0d row %0d",
                                 $signed(got.value), got.column, got.row));
                return;
            end
            want = pending_words.pop_front();
            if (got.value !== want.value)
                report($sformatf("filtered_value %0d, expected %0d (column %0d row %0d)",
                                 $signed(got.value), $signed(want.value),
                                 want.column, want.row));
            if (got.column !== want.column)
                report($sformatf("centre_column %0d, expected %0d",
                                 got.column, want.column));
            if (got.row !== want.row)
                report($sformatf("centre_row %0d, expected %0d", got.row, want.row));
            if (got.last !== want.last)
                report($sformatf("frame_last %0b, expected %0b (column %0d row %0d)",
                                 got.last, want.last, want.column, want.row));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    pix_t                   pixel_value;
    logic                   out_valid;
    logic                   out_ready;
    logic [PIX_W-1:0]       filtered_value;
    logic [COORD_W-1:0]     centre_column;
    logic [COORD_W-1:0]     centre_row;
    logic                   frame_last;

    // idling switches: when set, that side never idles
    bit                     in_calm;
    bit                     out_calm;
    int unsigned            cycle_count;
    conv_scoreboard         sb;

    image_conv3x3_stream uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pixel_value    (pixel_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .filtered_value (filtered_value),
        .centre_column  (centre_column),
        .centre_row     (centre_row),
        .frame_last     (frame_last)
    );

    // 20 ns clock, first rising edge at 10 ns
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Compare every word taken from the output channel. Outputs are read in
    // the active region of the rising edge, so they still hold pre-edge values.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_word({filtered_value, centre_column, centre_row, frame_last});
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int unsigned draw_gap(bit calm);
        return calm ? 0 : $urandom_range(15, 0);
    endfunction

    // Mostly full-range noise, with a share of extremes and small values so
    // that low shifts still give readable sums.
    function automatic pix_t pick_pixel();
        case ($urandom_range(9, 0))
            0:
                case ($urandom_range(3, 0))
                    0:       return PIX_MIN;
                    1:       return PIX_MAX;
                    2:       return 16'sd0;
                    default: return -16'sd1;
                endcase
            1:       return pix_t'($urandom_range(127, 0)) - 16'sd64;
            default: return pix_t'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_kernel_row();
        logic [CFG_DATA_W-1:0] row;
        for (int kx = 0; kx < KDIM; kx++)
            case ($urandom_range(9, 0))
                0:       row[PIX_W*kx +: PIX_W] = PIX_MIN;
                1:       row[PIX_W*kx +: PIX_W] = PIX_MAX;
                2, 3, 4: row[PIX_W*kx +: PIX_W] = pix_t'($urandom_range(16, 0)) - 16'sd8;
                default: row[PIX_W*kx +: PIX_W] = 16'($urandom);
            endcase
        return row;
    endfunction

    // Place a field value under random junk in the unused upper bits; the
    // register must keep only its own width.
    function automatic logic [CFG_DATA_W-1:0] pad_field(int unsigned v, int unsigned w);
        logic [CFG_DATA_W-1:0] mask;
        mask = (48'd1 << w) - 48'd1;
        return ({16'($urandom), 32'($urandom)} & ~mask) | (48'(v) & mask);
    endfunction

    // One register write; the shadow copy updates at the same edge.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] reg_index,
                             input logic [CFG_DATA_W-1:0]  reg_data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= reg_data;
        @(posedge clk);
        sb.write_reg(reg_index, reg_data);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Present one pixel after a random gap and hold it until taken. With no
    // gap, valid stays high from the previous word.
    task automatic send_pixel(input pix_t p);
        int unsigned gap;
        gap = draw_gap(in_calm);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel_value <= p;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.take_pixel(p);
    endtask

    // Drop valid after the last pixel of a burst so it is not taken twice.
    task automatic drop_valid();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic send_burst(input int unsigned count);
        repeat (count) send_pixel(pick_pixel());
        drop_valid();
    endtask

    // Wait for every owed word, then give border pixels still in the
    // pipeline time to clear before any register changes.
    task automatic wait_drained();
        while (sb.pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Output side: before each word, hold ready low for a random stall.
    initial
    begin
        int unsigned stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap(out_calm);
            @(negedge clk);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned sent;
        int unsigned count;
        int unsigned w_top;
        int unsigned frame;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        pixel_value = '0;
        in_calm     = 1'b0;
        out_calm    = 1'b0;
        cycle_count = 0;
        sb          = new();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Smallest frame, sizes below three act as three. All coefficients
        // at the negative extreme, no shift, pixels toggling between the
        // extremes. Spare indexes must not disturb any register.
        write_reg(REG_IMAGE_WIDTH, 48'd0);
        write_reg(REG_IMAGE_HEIGHT, pad_field(2, SIZE_W));
        write_reg(REG_RESULT_SHIFT, 48'd0);
        write_reg(REG_KERNEL_TOP, 48'h8000_8000_8000);
        write_reg(REG_KERNEL_MIDDLE, 48'h8000_8000_8000);
        write_reg(REG_KERNEL_BOTTOM, 48'h8000_8000_8000);
        write_reg(SPARE_INDEX_A, {16'($urandom), 32'($urandom)});
        write_reg(SPARE_INDEX_B, 48'hFFFF_FFFF_FFFF);
        for (int i = 0; i < 9; i++)
            send_pixel(i[0] ? PIX_MAX : PIX_MIN);
        drop_valid();
        wait_drained();

        // Mixed extreme coefficients, shift above the top acts as the top.
        write_reg(REG_KERNEL_TOP, 48'h8000_7FFF_0001);
        write_reg(REG_KERNEL_MIDDLE, 48'h7FFF_7FFF_7FFF);
        write_reg(REG_KERNEL_BOTTOM, 48'hFFFF_0000_8000);
        write_reg(REG_RESULT_SHIFT, pad_field(63, SHIFT_W));
        for (int i = 0; i < 9; i++)
            case (i % 4)
                0:       send_pixel(PIX_MAX);
                1:       send_pixel(PIX_MIN);
                2:       send_pixel(16'sd0);
                default: send_pixel(-16'sd1);
            endcase
        drop_valid();
        wait_drained();

        // Widest row: an oversize width acts as the line store depth.
        // Three rows reach the last centre column and the frame end.
        write_reg(REG_IMAGE_WIDTH, pad_field(2047, SIZE_W));
        write_reg(REG_IMAGE_HEIGHT, pad_field(3, SIZE_W));
        write_reg(REG_RESULT_SHIFT, pad_field(20, SHIFT_W));
        write_reg(REG_KERNEL_TOP, pick_kernel_row());
        write_reg(REG_KERNEL_MIDDLE, pick_kernel_row());
        write_reg(REG_KERNEL_BOTTOM, pick_kernel_row());
        send_burst(sb.pixels_to_frame_end());
        wait_drained();

        // Cut the size in mid-frame: the counters sit past the new last
        // column and row, so the next pixel closes the frame.
        write_reg(REG_IMAGE_WIDTH, pad_field(8, SIZE_W));
        write_reg(REG_IMAGE_HEIGHT, pad_field(6, SIZE_W));
        send_burst(20);
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, pad_field(3, SIZE_W));
        write_reg(REG_IMAGE_HEIGHT, pad_field(3, SIZE_W));
        send_burst(sb.pixels_to_frame_end() + 9);
        wait_drained();

        // Random bursts. Most run to a frame end, some stop mid-frame. In
        // mid-frame the width may only shrink, so no line store entry is
        // read before this frame has written it.
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            in_calm  = ($urandom_range(3, 0) == 0);
            out_calm = ($urandom_range(3, 0) == 0);

            if ($urandom_range(2, 0) == 0)
                write_reg(REG_KERNEL_TOP, pick_kernel_row());
            if ($urandom_range(2, 0) == 0)
                write_reg(REG_KERNEL_MIDDLE, pick_kernel_row());
            if ($urandom_range(2, 0) == 0)
                write_reg(REG_KERNEL_BOTTOM, pick_kernel_row());

            if ($urandom_range(2, 0) == 0)
            begin
                w_top = sb.mid_frame() ? sb.width_eff() : 12;
                if (w_top > 12)
                    w_top = 12;
                if ($urandom_range(5, 0) == 0)
                    write_reg(REG_IMAGE_WIDTH, pad_field($urandom_range(2, 0), SIZE_W));
                else
                    write_reg(REG_IMAGE_WIDTH, pad_field($urandom_range(w_top, 3), SIZE_W));
            end

            if ($urandom_range(2, 0) == 0)
                case ($urandom_range(19, 0))
                    0:       write_reg(REG_IMAGE_HEIGHT, pad_field(2047, SIZE_W));
                    1:       write_reg(REG_IMAGE_HEIGHT, pad_field($urandom_range(2, 0), SIZE_W));
                    default: write_reg(REG_IMAGE_HEIGHT, pad_field($urandom_range(8, 3), SIZE_W));
                endcase

            if ($urandom_range(2, 0) == 0)
                case ($urandom_range(4, 0))
                    0:       write_reg(REG_RESULT_SHIFT, pad_field($urandom_range(63, 39), SHIFT_W));
                    1:       write_reg(REG_RESULT_SHIFT, pad_field(0, SHIFT_W));
                    default: write_reg(REG_RESULT_SHIFT, pad_field($urandom_range(38, 1), SHIFT_W));
                endcase

            frame = sb.width_eff() * sb.height_eff();
            if ($urandom_range(9, 0) < 7)
                count = sb.pixels_to_frame_end() + $urandom_range(1, 0) * frame;
            else
                count = $urandom_range(40, 1);
            // keep tall frames short; they are finished by a later size cut
            if (count > 300)
                count = $urandom_range(60, 1);

            send_burst(count);
            wait_drained();
            sent += count;
        end

        in_calm  = 1'b0;
        out_calm = 1'b0;
        wait_drained();

        if (sb.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/ic3s_pkg.sv
hdl/ic3s_front.sv
hdl/ic3s_queue.sv
hdl/ic3s_back.sv
hdl/image_conv3x3_stream.sv
hdl/ic3s_checker.sv
sim/image_conv3x3_stream_test.sv
